// ===== hw/rtl/earliest_free_worker_dispatch_top_defines.svh =====
// Assertion macros shared by the dispatch block.
`ifndef EARLIEST_FREE_WORKER_DISPATCH_TOP_DEFINES_SVH
`define EARLIEST_FREE_WORKER_DISPATCH_TOP_DEFINES_SVH

`define EFWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define EFWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/efwd_pkg.sv =====
// Types and constants of the earliest-free worker dispatch block.
package efwd_pkg;

  localparam int DUR_W     = 32;
  localparam int TIME_W    = 48;
  localparam int OUT_IDX_W = 4;
  localparam int CNT_W     = 5;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(16);

  localparam logic [0:0] REG_WORKER_COUNT = 1'b0;

  typedef logic [DUR_W-1:0]     dur_t;
  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [OUT_IDX_W-1:0] out_idx_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } sts_t;

endpackage

// ===== hw/rtl/efwd_if.sv =====
// Valid/ready channels for job beats and dispatch result beats.
interface efwd_job_if import efwd_pkg::*;;
  logic valid;
  logic ready;
  dur_t job_duration;

  modport source (output valid, output job_duration, input ready);
  modport sink (input valid, input job_duration, output ready);
endinterface

interface efwd_res_if import efwd_pkg::*;;
  logic     valid;
  logic     ready;
  out_idx_t worker_index;
  time_t    start_time;

  modport source (output valid, output worker_index, output start_time, input ready);
  modport sink (input valid, input worker_index, input start_time, output ready);
endinterface

// ===== hw/rtl/efwd_cfg.sv =====
// Configuration register file holding the worker count.
module efwd_cfg import efwd_pkg::*; #(
  parameter int MAX_WORKERS = 16,
  parameter int IDX_W       = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  output logic [IDX_W-1:0]      active_last_o
);

  localparam int NW = ($clog2(MAX_WORKERS + 1) > CNT_W) ? $clog2(MAX_WORKERS + 1) : CNT_W;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NW-1:0]    cnt_ext;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[APB_AW-1] == REG_WORKER_COUNT);

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en) begin
      cnt_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_RESET;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1] == REG_WORKER_COUNT) begin
      prdata = APB_DW'(cnt_q);
    end
  end

  assign cnt_ext = NW'(cnt_q);

  always_comb begin
    if (cnt_ext == '0) begin
      active_last_o = '0;
    end else if (cnt_ext > NW'(MAX_WORKERS)) begin
      active_last_o = IDX_W'(MAX_WORKERS - 1);
    end else begin
      active_last_o = IDX_W'(cnt_ext - NW'(1));
    end
  end

endmodule

// ===== hw/rtl/efwd_sched.sv =====
// Free-time memory with the scan, update and result register of the dispatcher.
module efwd_sched import efwd_pkg::*; #(
  parameter int MAX_WORKERS = 16,
  parameter int IDX_W       = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] active_last_i,
  efwd_job_if.sink         job_i,
  efwd_res_if.source       res_o,
  output sts_t             sts_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(MAX_WORKERS - 1);

  time_t mem_q [MAX_WORKERS];
  time_t mem_rdata_q;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  time_t            best_q, best_d;
  dur_t             dur_q, dur_d;
  logic             out_valid_q, out_valid_d;
  out_idx_t         out_idx_q, out_idx_d;
  time_t            out_time_q, out_time_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  time_t            mem_wdata;
  logic [TIME_W:0]  sum;
  logic             take;
  logic             out_load;

  assign sum      = {1'b0, best_q} + (TIME_W + 1)'(dur_q);
  assign take     = (cmp_idx_q == '0) || (mem_rdata_q < best_q);
  assign out_load = (state_q == ST_WRITE) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmp_idx_d   = cmp_idx_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    dur_d       = dur_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_time_d  = out_time_q;
    mem_we      = 1'b0;
    mem_waddr   = best_idx_q;
    mem_wdata   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    mem_raddr   = cmp_idx_q + IDX_W'(1);

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == LAST_ENTRY) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_raddr = '0;
        if (job_i.valid) begin
          dur_d     = job_i.job_duration;
          cmp_idx_d = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_d     = mem_rdata_q;
          best_idx_d = cmp_idx_q;
        end
        cmp_idx_d = cmp_idx_q + IDX_W'(1);
        if (cmp_idx_q == active_last_i) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_load) begin
          mem_we      = 1'b1;
          out_valid_d = 1'b1;
          out_idx_d   = OUT_IDX_W'(best_idx_q);
          out_time_d  = best_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    dur_q      <= dur_d;
    out_idx_q  <= out_idx_d;
    out_time_q <= out_time_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  assign job_i.ready        = (state_q == ST_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.worker_index = out_idx_q;
  assign res_o.start_time   = out_time_q;

  assign sts_o.clearing = (state_q == ST_CLEAR);
  assign sts_o.busy     = (state_q == ST_SCAN) || (state_q == ST_WRITE);

endmodule

// ===== hw/rtl/earliest_free_worker_dispatch_top.sv =====
// Top level of the earliest-free worker dispatch block.
// Each job beat is given to the worker in use whose free time is smallest, the lowest index
// winning a tie, and one result beat reports that worker and the job's start time; the
// worker's free time then advances by the duration and saturates at the top of its 48-bit
// range. The free times sit in one memory with a single read port that the search walks
// one entry per cycle over the n workers in use, followed by a write state that writes back
// and loads the result register once that register is free. A new job is taken while an
// earlier result still waits to be collected. After reset the memory is cleared entry by
// entry, during which no job is taken; the worker count register at byte address 0 is to
// be written only while no job is in flight.
module earliest_free_worker_dispatch_top import efwd_pkg::*; #(
  parameter int MAX_WORKERS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  efwd_job_if.sink          job_i,
  efwd_res_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

`include "earliest_free_worker_dispatch_top_defines.svh"

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  logic [IDX_W-1:0] active_last;
  sts_t             sts;

  efwd_cfg #(
    .MAX_WORKERS (MAX_WORKERS),
    .IDX_W       (IDX_W)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .active_last_o (active_last)
  );

  efwd_sched #(
    .MAX_WORKERS (MAX_WORKERS),
    .IDX_W       (IDX_W)
  ) u_sched (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .active_last_i (active_last),
    .job_i         (job_i),
    .res_o         (res_o),
    .sts_o         (sts)
  );

  `EFWD_ASSERT_NEXT(a_busy_after_accept, job_i.valid && job_i.ready, !job_i.ready, "job taken while a search runs")
  `EFWD_ASSERT_NOW(a_no_job_in_clear, sts.clearing, !job_i.ready, "job taken during the clearing pass")
  `EFWD_ASSERT_NOW(a_result_after_search, $fell(sts.busy), res_o.valid, "search ended without a result beat")

endmodule

// ===== test/efwd_dispatch_checker.sv =====
// Checker that predicts every dispatch of the block and compares each result beat against it.
`timescale 1ns / 100ps

module efwd_dispatch_checker import efwd_pkg::*; #(
  parameter int MAX_WORKERS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  efwd_job_if               job_i,
  efwd_res_if               res_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  input  logic [APB_DW-1:0] prdata_i,
  input  logic              pready_i,
  output int                mismatches_o,
  output int                results_seen_o,
  output int                waiting_o
);

  localparam int    REPORT_LIMIT = 10;
  localparam time_t TIME_MAX     = '1;

  typedef struct packed {
    out_idx_t worker;
    time_t    start;
  } dispatch_t;

  time_t            free_time [MAX_WORKERS];
  logic [CNT_W-1:0] worker_count;
  dispatch_t        expected_dispatches [$];
  int               mismatches   = 0;
  int               results_seen = 0;

  function automatic int workers_in_use();
    if (worker_count == '0) return 1;
    if (int'(worker_count) > MAX_WORKERS) return MAX_WORKERS;
    return int'(worker_count);
  endfunction

  // The earliest free worker takes the job; a strict compare keeps the lowest index on a tie.
  function automatic dispatch_t dispatch_job(input dur_t dur);
    int              best;
    logic [TIME_W:0] advanced;
    dispatch_t       d;
    best = 0;
    for (int w = 1; w < workers_in_use(); w++) begin
      if (free_time[w] < free_time[best]) best = w;
    end
    d.worker = out_idx_t'(best);
    d.start  = free_time[best];
    advanced = {1'b0, free_time[best]} + (TIME_W+1)'(dur);
    free_time[best] = advanced[TIME_W] ? TIME_MAX : advanced[TIME_W-1:0];
    return d;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_t got;
    dispatch_t want;
    if (!rst_ni) begin
      foreach (free_time[w]) free_time[w] = '0;
      worker_count = CNT_RESET;
      expected_dispatches.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[APB_AW-1:2] == REG_WORKER_COUNT) begin
        if (pwrite_i) begin
          worker_count = pwdata_i[CNT_W-1:0];
        end else if (prdata_i !== APB_DW'(worker_count)) begin
          note_mismatch($sformatf("worker count read back %0d, expected %0d",
                                  prdata_i, worker_count));
        end
      end
      if (job_i.valid && job_i.ready) begin
        expected_dispatches.push_back(dispatch_job(job_i.job_duration));
      end
      if (res_i.valid && res_i.ready) begin
        got.worker = res_i.worker_index;
        got.start  = res_i.start_time;
        results_seen++;
        if (expected_dispatches.size() == 0) begin
          note_mismatch($sformatf("result beat with nothing expected: worker %0d start %0d",
                                  got.worker, got.start));
        end else begin
          want = expected_dispatches.pop_front();
          if (got.worker !== want.worker || got.start !== want.start) begin
            note_mismatch($sformatf("got worker %0d start %0d, expected worker %0d start %0d",
                                    got.worker, got.start, want.worker, want.start));
          end
        end
      end
    end
    mismatches_o   <= mismatches;
    results_seen_o <= results_seen;
    waiting_o      <= expected_dispatches.size();
  end

endmodule

// ===== test/tb_earliest_free_worker_dispatch_top.sv =====
// Testbench top: drives job beats and register writes into the dispatch block and gives the verdict.
`timescale 1ns / 100ps

module tb_earliest_free_worker_dispatch_top;
  import efwd_pkg::*;

  localparam int MAX_WORKERS    = 16;
  localparam int REG_SPARE_IDX  = 1;
  localparam int MAX_GAP        = 19;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_JOBS     = 95;
  localparam int TAIL_CYCLES    = 2 * MAX_WORKERS + 4;
  localparam logic [APB_AW-1:0] ADDR_WORKER_COUNT = APB_AW'(REG_WORKER_COUNT) << 2;
  localparam logic [APB_AW-1:0] ADDR_SPARE        = APB_AW'(REG_SPARE_IDX) << 2;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int   jobs_sent     = 0;
  int   hold_requests = 0;
  int   mismatches;
  int   results_seen;
  int   waiting;
  logic src_gaps_on   = 1'b1;
  logic snk_gaps_on   = 1'b1;

  efwd_job_if job_ch ();
  efwd_res_if res_ch ();

  earliest_free_worker_dispatch_top #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  efwd_dispatch_checker #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_ch),
    .res_i          (res_ch),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .mismatches_o   (mismatches),
    .results_seen_o (results_seen),
    .waiting_o      (waiting)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic dur_t draw_duration();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return dur_t'($urandom_range(0, 15));
      5:             return '0;
      6:             return '1;
      default:       return dur_t'($urandom);
    endcase
  endfunction

  task automatic push_job(input dur_t dur);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      job_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    job_ch.valid        <= 1'b1;
    job_ch.job_duration <= dur;
    do @(posedge clk_i); while (!job_ch.ready);
    jobs_sent++;
  endtask

  task automatic wait_idle();
    job_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_seen != jobs_sent);
  endtask

  task automatic apb_access(input logic write, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_workers(input logic [APB_DW-1:0] data);
    apb_access(1'b1, ADDR_WORKER_COUNT, data);
    apb_access(1'b0, ADDR_WORKER_COUNT, '0);
  endtask

  // The receiver takes a long hold-off whenever one has been requested, so the block backs up.
  initial begin : result_sink
    int stall;
    int holds_done;
    holds_done = 0;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = snk_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (holds_done < hold_requests) begin
        stall = HOLD_CYCLES;
        holds_done++;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
    end
  end

  initial begin : stimulus
    int               wc;
    logic [APB_DW-1:0] wdata;
    rst_ni              <= 1'b0;
    job_ch.valid        <= 1'b0;
    job_ch.job_duration <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset count, ties among all-zero free times, and duration extremes.
    push_job('0);
    push_job('1);
    push_job(dur_t'(1));
    push_job(dur_t'(32'h8000_0000));
    push_job(dur_t'(32'h5555_5555));
    push_job(dur_t'(32'hAAAA_AAAA));
    push_job('0);
    push_job('0);
    wait_idle();
    // A count of zero behaves as one worker.
    set_workers('0);
    push_job('1);
    push_job(dur_t'(3));
    wait_idle();
    // Counts above the pool size are clamped.
    set_workers(APB_DW'(31));
    push_job('0);
    push_job('0);
    push_job(dur_t'(7));
    wait_idle();
    set_workers(APB_DW'(17));
    push_job(dur_t'(2));
    wait_idle();
    // Shrinking the pool parks the upper workers, and writes to the spare address do nothing.
    set_workers(APB_DW'(2));
    push_job(dur_t'(5));
    push_job(dur_t'(5));
    wait_idle();
    apb_access(1'b1, ADDR_SPARE, '1);
    push_job(dur_t'(1));
    wait_idle();
    set_workers(APB_DW'(MAX_WORKERS));
    push_job('0);
    push_job('0);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       wc = 1;
        1:       wc = MAX_WORKERS;
        2:       wc = 0;
        3:       wc = 31;
        default: wc = $urandom_range(0, 31);
      endcase
      wdata = $urandom;
      wdata[CNT_W-1:0] = CNT_W'(wc);
      set_workers(wdata);
      if ($urandom_range(0, 1) == 0) apb_access(1'b1, ADDR_SPARE, $urandom);
      src_gaps_on = $urandom_range(0, 3) != 0;
      snk_gaps_on = $urandom_range(0, 3) != 0;
      if (ph == 1 || ph == 4) begin
        src_gaps_on = 1'b0;
        hold_requests++;
      end
      repeat (PHASE_JOBS) push_job(draw_duration());
      wait_idle();
    end

    src_gaps_on = 1'b1;
    snk_gaps_on = 1'b1;
    set_workers(APB_DW'(MAX_WORKERS));
    repeat (20) push_job(draw_duration());
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
